@@ design/dtsc_pkg.sv @@
package dtsc_pkg;

	// field widths
	localparam int PCW        = 12;
	localparam int MVW        = 12;
	localparam int DEPTH_OUTW = 16;
	localparam int TEMP_OUTW  = 16;
	localparam int PZ_W       = 12;
	localparam int GAIN_W     = 20;
	localparam int DOFF_W     = 12;
	localparam int TOFF_W     = 14;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// internal state widths
	localparam int DSTATE_W = 20;
	localparam int TSTATE_W = 20;
	localparam int TICK_W   = 16;

	// default adc resolution
	localparam int ADC_BITS_DEF = 12;

	// register reset values
	localparam logic [PZ_W-1:0]     PZ_RST     = PZ_W'(408);
	localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(361667);
	localparam logic [DOFF_W-1:0]   DOFF_RST   = DOFF_W'(399);
	localparam logic [TOFF_W-1:0]   TOFF_RST   = TOFF_W'(5000);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(10000);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESSURE_ZERO  = 3'd0,
		CFG_DEPTH_GAIN     = 3'd1,
		CFG_DEPTH_OFFSET   = 3'd2,
		CFG_TEMP_OFFSET    = 3'd3,
		CFG_PUBLISH_PERIOD = 3'd4
	} cfg_idx_t;

	// item kinds
	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef struct packed {
		logic           func;
		logic [PCW-1:0] pressure_counts;
		logic [MVW-1:0] temp_mv;
		logic           bus_busy;
	} in_item_t;

	typedef struct packed {
		logic        [DEPTH_OUTW-1:0] depth_out;
		logic signed [TEMP_OUTW-1:0]  temp_filtered;
		logic signed [TEMP_OUTW-1:0]  temp_raw;
		logic        [PCW-1:0]        pressure_echo;
		logic                         published;
	} out_item_t;

	typedef struct packed {
		logic [PZ_W-1:0]     pressure_zero;
		logic [GAIN_W-1:0]   depth_gain;
		logic [DOFF_W-1:0]   depth_offset;
		logic [TOFF_W-1:0]   temp_offset;
		logic [PERIOD_W-1:0] publish_period;
	} cfg_t;

endpackage

@@ design/dtsc_cfg_regs.sv @@
module dtsc_cfg_regs
	import dtsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressure_zero  <= PZ_RST;
			cfg_q.depth_gain     <= GAIN_RST;
			cfg_q.depth_offset   <= DOFF_RST;
			cfg_q.temp_offset    <= TOFF_RST;
			cfg_q.publish_period <= PERIOD_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_PRESSURE_ZERO:  cfg_q.pressure_zero  <= wr_data[PZ_W-1:0];
				CFG_DEPTH_GAIN:     cfg_q.depth_gain     <= wr_data[GAIN_W-1:0];
				CFG_DEPTH_OFFSET:   cfg_q.depth_offset   <= wr_data[DOFF_W-1:0];
				CFG_TEMP_OFFSET:    cfg_q.temp_offset    <= wr_data[TOFF_W-1:0];
				CFG_PUBLISH_PERIOD: cfg_q.publish_period <= wr_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/dtsc_core.sv @@
module dtsc_core
	import dtsc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	localparam int DIFF_W = PCW + 1;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;
	localparam int SUM_W  = DSTATE_W + 6;
	localparam int CRAW_W = 18;
	localparam int TSUM_W = TSTATE_W + 4;
	localparam int FRAC_SHIFT = 12;

	localparam logic [PCW-1:0] P_MASK = PCW'((33'd1 << ADC_BITS) - 33'd1);
	localparam logic signed [SUM_W-1:0] DEPTH_MAX = SUM_W'((1 << DSTATE_W) - 1);
	localparam logic signed [CRAW_W-1:0] CRAW_MAX = CRAW_W'(32767);
	localparam logic signed [CRAW_W-1:0] CRAW_MIN = -CRAW_W'(32768);
	localparam logic signed [TSUM_W-1:0] TS_MAX = TSUM_W'((1 << (TSTATE_W - 1)) - 1);
	localparam logic signed [TSUM_W-1:0] TS_MIN = -TSUM_W'(1 << (TSTATE_W - 1));

	logic        [DSTATE_W-1:0] depth_state_q;
	logic signed [TSTATE_W-1:0] temp_state_q;
	logic        [TICK_W-1:0]   tick_count_q;
	logic                       pending_q;

	logic        [PCW-1:0]      p;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SUM_W-1:0]    dsum;
	logic signed [SUM_W-1:0]    dfilt;
	logic        [DSTATE_W-1:0] depth_next;
	logic signed [CRAW_W-1:0]   craw;
	logic signed [TEMP_OUTW-1:0] craw_sat;
	logic signed [TSUM_W-1:0]   tsum;
	logic signed [TSUM_W-1:0]   tfilt;
	logic signed [TSTATE_W-1:0] temp_next;
	logic                       pub;

	// depth: gain and offset, then 1/8 filter and clamp
	always_comb begin
		p    = item.pressure_counts & P_MASK;
		diff = $signed({1'b0, p}) - $signed({1'b0, cfg.pressure_zero});
		prod = PROD_W'(diff) * PROD_W'($signed({1'b0, cfg.depth_gain}));
		dsum = SUM_W'(prod >>> FRAC_SHIFT)
			+ $signed(SUM_W'({cfg.depth_offset, 4'b0000}))
			+ $signed(SUM_W'({depth_state_q, 3'b000}))
			- $signed(SUM_W'(depth_state_q));
		dfilt = dsum >>> 3;
		if (dfilt[SUM_W-1]) begin
			depth_next = '0;
		end else if (dfilt > DEPTH_MAX) begin
			depth_next = DEPTH_MAX[DSTATE_W-1:0];
		end else begin
			depth_next = dfilt[DSTATE_W-1:0];
		end
	end

	// temperature: centidegrees, saturate, 1/8 filter
	always_comb begin
		craw = $signed(CRAW_W'({item.temp_mv, 3'b000}) + CRAW_W'({item.temp_mv, 1'b0})
			- CRAW_W'(cfg.temp_offset));
		if (craw > CRAW_MAX) begin
			craw_sat = CRAW_MAX[TEMP_OUTW-1:0];
		end else if (craw < CRAW_MIN) begin
			craw_sat = CRAW_MIN[TEMP_OUTW-1:0];
		end else begin
			craw_sat = craw[TEMP_OUTW-1:0];
		end
		tsum = (TSUM_W'(craw_sat) <<< 4) + (TSUM_W'(temp_state_q) <<< 3)
			- TSUM_W'(temp_state_q);
		tfilt = tsum >>> 3;
		if (tfilt > TS_MAX) begin
			temp_next = TS_MAX[TSTATE_W-1:0];
		end else if (tfilt < TS_MIN) begin
			temp_next = TS_MIN[TSTATE_W-1:0];
		end else begin
			temp_next = tfilt[TSTATE_W-1:0];
		end
	end

	assign pub = pending_q && !item.bus_busy;

	// filter state, tick counter and publish flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_state_q <= '0;
			temp_state_q  <= '0;
			tick_count_q  <= '0;
			pending_q     <= 1'b0;
		end else if (step) begin
			if (item.func == FUNC_TICK) begin
				if (tick_count_q > cfg.publish_period) begin
					pending_q    <= 1'b1;
					tick_count_q <= '0;
				end else begin
					tick_count_q <= tick_count_q + TICK_W'(1);
				end
			end else begin
				depth_state_q <= depth_next;
				temp_state_q  <= temp_next;
				if (pub) begin
					pending_q <= 1'b0;
				end
			end
		end
	end

	// result of a sample, from the updated state
	always_comb begin
		result.depth_out     = depth_next[DSTATE_W-1 -: DEPTH_OUTW];
		result.temp_filtered = TEMP_OUTW'(temp_next >>> 4);
		result.temp_raw      = craw_sat;
		result.pressure_echo = p;
		result.published     = pub;
	end

endmodule

@@ design/depth_temp_sensor_conditioner_unit.sv @@
// Depth and temperature conditioner.
// Input channel (in_valid / in_ready / in_item): each item is a timer tick
// or a sample pair (pressure counts, temperature mV, bus busy flag).
// Output channel (out_valid / out_ready / out_item): one result item per
// sample, none per tick; ticks only advance the publish counter.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready, write only while the block is idle.
// Path: an item is registered on acceptance and worked out from the input
// register through one multiplier and the two filter adders; its result is
// loaded into the output register when the item advances, and out_valid
// rises with it; a receiver stall can hold the item back.
// Throughput: one item per cycle while the receiver does not stall; the
// feedback through the filter state closes combinationally.
// Receiver stall: the output register holds its result; one further item
// waits in the input register, then in_ready drops. Ticks pass on even
// while a result waits.
// Reset: filter state, tick counter and pending publish clear, registers
// return to their defaults, both pipeline registers empty.
module depth_temp_sensor_conditioner_unit
	import dtsc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      adv;
	out_item_t result;
	out_item_t out_q;
	logic      out_valid_q;

	assign cfg_ready = 1'b1;

	dtsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// a tick always moves on, a sample needs room in the output register
	assign adv = valid_s1 && (item_s1.func == FUNC_TICK || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	dtsc_core #(
		.ADC_BITS (ADC_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && item_s1.func == FUNC_SAMPLE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.func == FUNC_SAMPLE) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ test/tb_depth_temp_sensor_conditioner_unit.sv @@
`timescale 1ns / 100ps

module tb_depth_temp_sensor_conditioner_unit;
	import dtsc_pkg::*;

	localparam int HOLD_LONG  = 400;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE     = 4;
	localparam int PRINT_CAP  = 50;
	localparam longint DEPTH_TOP = 64'sd1048575;
	localparam longint TSTATE_HI = 64'sd524287;
	localparam longint TSTATE_LO = -64'sd524288;

	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd5;

	typedef enum int {RX_FREE, RX_COIN, RX_SLOW} rx_mode_t;
	typedef enum int {PROF_MIXED, PROF_DEEP, PROF_SHALLOW} profile_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	depth_temp_sensor_conditioner_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow registers and filter state
	logic [PZ_W-1:0]            shadow_zero   = PZ_RST;
	logic [GAIN_W-1:0]          shadow_gain   = GAIN_RST;
	logic [DOFF_W-1:0]          shadow_doff   = DOFF_RST;
	logic [TOFF_W-1:0]          shadow_toff   = TOFF_RST;
	logic [PERIOD_W-1:0]        shadow_period = PERIOD_RST;
	logic [DSTATE_W-1:0]        depth_acc     = '0;
	logic signed [TSTATE_W-1:0] temp_acc      = '0;
	logic [TICK_W-1:0]          tick_cnt      = '0;
	logic                       publish_armed = 1'b0;

	in_item_t  pending_items[$];
	out_item_t expected_readings[$];
	int        fault_count = 0;
	int        hold_asks   = 0;
	int        hold_served = 0;

	task automatic report_bad(input string what);
		if (fault_count < PRINT_CAP)
			$display("ERROR at %0t: %s", $time, what);
		fault_count++;
	endtask

	// register write as the block sees it
	function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
		CFG_PRESSURE_ZERO:  shadow_zero   = val[PZ_W-1:0];
		CFG_DEPTH_GAIN:     shadow_gain   = val[GAIN_W-1:0];
		CFG_DEPTH_OFFSET:   shadow_doff   = val[DOFF_W-1:0];
		CFG_TEMP_OFFSET:    shadow_toff   = val[TOFF_W-1:0];
		CFG_PUBLISH_PERIOD: shadow_period = val[PERIOD_W-1:0];
		default: ;
		endcase
	endfunction

	// one item through the conditioner; returns 1 when a result is due
	function automatic bit condition_item(input in_item_t it, output out_item_t res);
		longint diff, raw, dfilt, craw, tfilt, tshow;
		bit pub;
		res = '0;
		if (it.func == FUNC_TICK) begin
			if (tick_cnt > shadow_period) begin
				publish_armed = 1'b1;
				tick_cnt = '0;
			end else begin
				tick_cnt = tick_cnt + 1'b1;
			end
			return 1'b0;
		end
		// depth: gain and offset, then 1/8 filter with clamp
		diff = longint'(it.pressure_counts) - longint'(shadow_zero);
		raw = ((diff * longint'(shadow_gain)) >>> 12) + longint'(shadow_doff) * 16;
		dfilt = (raw + 7 * longint'(depth_acc)) >>> 3;
		if (dfilt < 0)
			dfilt = 0;
		if (dfilt > DEPTH_TOP)
			dfilt = DEPTH_TOP;
		depth_acc = dfilt[DSTATE_W-1:0];
		// temperature: centidegrees with saturation, then 1/8 filter
		craw = 10 * longint'(it.temp_mv) - longint'(shadow_toff);
		if (craw > 32767)
			craw = 32767;
		if (craw < -32768)
			craw = -32768;
		tfilt = (craw * 16 + 7 * longint'(temp_acc)) >>> 3;
		if (tfilt > TSTATE_HI)
			tfilt = TSTATE_HI;
		if (tfilt < TSTATE_LO)
			tfilt = TSTATE_LO;
		temp_acc = tfilt[TSTATE_W-1:0];
		tshow = longint'(temp_acc) >>> 4;
		// publish on a free bus
		pub = publish_armed && !it.bus_busy;
		if (pub)
			publish_armed = 1'b0;
		res.depth_out     = depth_acc[DSTATE_W-1:4];
		res.temp_filtered = tshow[TEMP_OUTW-1:0];
		res.temp_raw      = craw[TEMP_OUTW-1:0];
		res.pressure_echo = it.pressure_counts;
		res.published     = pub;
		return 1'b1;
	endfunction

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin : monitor
		out_item_t want;
		out_item_t fresh;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				shadow_write(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				if (condition_item(in_item, fresh))
					expected_readings.push_back(fresh);
			end
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					report_bad("result item with nothing expected");
				end else begin
					want = expected_readings.pop_front();
					if (out_item.depth_out !== want.depth_out)
						report_bad($sformatf("depth_out got %0d want %0d",
							out_item.depth_out, want.depth_out));
					if (out_item.temp_filtered !== want.temp_filtered)
						report_bad($sformatf("temp_filtered got %0d want %0d",
							out_item.temp_filtered, want.temp_filtered));
					if (out_item.temp_raw !== want.temp_raw)
						report_bad($sformatf("temp_raw got %0d want %0d",
							out_item.temp_raw, want.temp_raw));
					if (out_item.pressure_echo !== want.pressure_echo)
						report_bad($sformatf("pressure_echo got %0d want %0d",
							out_item.pressure_echo, want.pressure_echo));
					if (out_item.published !== want.published)
						report_bad($sformatf("published got %0b want %0b",
							out_item.published, want.published));
				end
			end
		end
	end

	// driver: bursts of items with random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin : driver
		if (arst_n && !(in_valid && !in_ready)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() > 0) begin
				in_item  <= pending_items.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 32);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern plus long hold-offs on request
	rx_mode_t rx_mode   = RX_FREE;
	int       rx_left   = 0;
	int       hold_left = 0;

	always @(posedge clk) begin : receiver
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_served) begin
			out_ready   <= 1'b0;
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_LONG;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				rx_left <= $urandom_range(16, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
			RX_FREE: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// watchdog on cycles with no handshake at all
	int idle_cycles = 0;

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("depth_temp_sensor_conditioner_unit: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic void queue_item(input logic func, input int unsigned p,
			input int unsigned mv, input logic busy);
		in_item_t it;
		it.func            = func;
		it.pressure_counts = PCW'(p);
		it.temp_mv         = MVW'(mv);
		it.bus_busy        = busy;
		pending_items.push_back(it);
	endfunction

	function automatic int unsigned pick_value(input int unsigned hi);
		case ($urandom_range(0, 3))
		0: return 0;
		1: return hi;
		default: return $urandom_range(0, hi);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input int unsigned pz, input int unsigned gain,
			input int unsigned doff, input int unsigned toff, input int unsigned period);
		write_reg(CFG_PRESSURE_ZERO, pz);
		write_reg(CFG_DEPTH_GAIN, gain);
		write_reg(CFG_DEPTH_OFFSET, doff);
		write_reg(CFG_TEMP_OFFSET, toff);
		write_reg(CFG_PUBLISH_PERIOD, period);
	endtask

	// wait until all items are in and every result has come back
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_config(input profile_t prof);
		int unsigned toff, period;
		toff   = ($urandom_range(0, 9) == 0) ? 16383 : pick_value(10000);
		period = ($urandom_range(0, 4) == 0) ? pick_value(65535) : $urandom_range(0, 24);
		case (prof)
		PROF_DEEP: configure($urandom_range(0, 8), 1048575 - $urandom_range(0, 2000),
			$urandom_range(3000, 4095), toff, period);
		PROF_SHALLOW: configure($urandom_range(3000, 4095), pick_value(1048575),
			$urandom_range(0, 64), toff, period);
		default: configure(pick_value(4095), pick_value(1048575), pick_value(4095),
			toff, period);
		endcase
	endtask

	task automatic random_phase(input profile_t prof, input int n);
		int unsigned p, mv;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 3) begin
				// ticks carry junk payload
				queue_item(FUNC_TICK, $urandom, $urandom, 1'($urandom));
			end else begin
				case (prof)
				PROF_DEEP:    p = $urandom_range(4060, 4095);
				PROF_SHALLOW: p = $urandom_range(0, 100);
				default:      p = pick_value(4095);
				endcase
				case ($urandom_range(0, 7))
				0: mv = 0;
				1: mv = 3300;
				2: mv = $urandom_range(3301, 4095);
				default: mv = $urandom_range(0, 3300);
				endcase
				queue_item(FUNC_SAMPLE, p, mv, ($urandom_range(0, 2) == 0));
			end
		end
	endtask

	initial begin : stimulus
		profile_t prof;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// defaults after reset: field extremes, temperature saturation
		queue_item(FUNC_SAMPLE, 0, 0, 1'b0);
		queue_item(FUNC_SAMPLE, 4095, 3300, 1'b1);
		queue_item(FUNC_TICK, 0, 0, 1'b0);
		queue_item(FUNC_SAMPLE, 408, 4095, 1'b0);
		drain();

		// negative depth clamp, publish held by busy bus then taken
		configure(4095, 1048575, 0, 10000, 1);
		write_reg(CFG_UNMAPPED, 20'hFFFFF);
		queue_item(FUNC_SAMPLE, 0, 0, 1'b0);
		repeat (3) queue_item(FUNC_TICK, 4095, 4095, 1'b1);
		queue_item(FUNC_SAMPLE, 100, 1000, 1'b1);
		queue_item(FUNC_SAMPLE, 200, 2000, 1'b0);
		queue_item(FUNC_SAMPLE, 300, 3000, 1'b0);
		drain();

		// climb towards depth saturation, period of zero
		configure(0, 1048575, 4095, 0, 0);
		repeat (5) queue_item(FUNC_SAMPLE, 4095, 4095, 1'b0);
		repeat (2) queue_item(FUNC_TICK, 0, 0, 1'b0);
		queue_item(FUNC_SAMPLE, 4095, 4095, 1'b0);
		drain();

		// random phases with fresh settings each time
		for (int k = 0; k < 14; k++) begin
			prof = (k % 5 == 1) ? PROF_DEEP : (k % 5 == 3) ? PROF_SHALLOW : PROF_MIXED;
			random_config(prof);
			if (k == 2 || k == 9)
				hold_asks++;
			random_phase(prof, 130);
			drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (expected_readings.size() != 0)
			report_bad($sformatf("%0d result items never arrived", expected_readings.size()));
		if (fault_count == 0) begin
			$display("depth_temp_sensor_conditioner_unit: match");
		end else begin
			$display("depth_temp_sensor_conditioner_unit: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/dtsc_pkg.sv
design/dtsc_cfg_regs.sv
design/dtsc_core.sv
design/depth_temp_sensor_conditioner_unit.sv
test/tb_depth_temp_sensor_conditioner_unit.sv
